### rtl/core/ime_character_width_mapper_top_macros.svh
// assertion macros for the character width mapper
`ifndef IME_CHARACTER_WIDTH_MAPPER_TOP_MACROS_SVH
`define IME_CHARACTER_WIDTH_MAPPER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed in character width mapper");
`define ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition in character width mapper");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

### rtl/core/ime_cwm_pkg.sv
// shared types, constants and mapping functions for the character width mapper
`timescale 1ns / 1ps
package ime_cwm_pkg;

	typedef enum logic [1:0] {
		KIND_KANA  = 2'd0,
		KIND_ALNUM = 2'd1,
		KIND_SPACE = 2'd2,
		KIND_RAW   = 2'd3
	} kind_t;

	localparam int unsigned CODE_W = 16;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned DATA_W = 64;

	localparam logic [IDX_W-1:0] REG_WIDTH_SELECT  = 3'd0;
	localparam logic [IDX_W-1:0] REG_PUNCT_STYLE   = 3'd1;
	localparam logic [IDX_W-1:0] REG_HALF_SYMBOLS  = 3'd2;
	localparam logic [IDX_W-1:0] REG_FORMS_LOW     = 3'd3;
	localparam logic [IDX_W-1:0] REG_FORMS_SECOND  = 3'd4;
	localparam logic [IDX_W-1:0] REG_FORMS_THIRD   = 3'd5;
	localparam logic [IDX_W-1:0] REG_FORMS_HIGH    = 3'd6;

	localparam logic [1:0] PUNCT_TOUTEN_KUTEN = 2'd0;
	localparam logic [1:0] PUNCT_FULL         = 2'd1;
	localparam logic [1:0] PUNCT_HALF         = 2'd2;
	localparam logic [1:0] PUNCT_TOUTEN_FULL  = 2'd3;

	localparam logic [1:0] FORM_FULL     = 2'd1;
	localparam logic [1:0] FORM_JAPANESE = 2'd2;

	localparam logic [DATA_W-1:0] FORMS_LOW_RST    = 64'd0;
	localparam logic [DATA_W-1:0] FORMS_SECOND_RST = 64'd9223372039136477192;
	localparam logic [DATA_W-1:0] FORMS_THIRD_RST  = 64'd612489549322387456;
	localparam logic [DATA_W-1:0] FORMS_HIGH_RST   = 64'd0;

	localparam logic [CODE_W-1:0] FULL_OFFSET  = 16'hFEE0;
	localparam logic [CODE_W-1:0] IDEO_SPACE   = 16'h3000;
	localparam logic [CODE_W-1:0] TOUTEN       = 16'h3001;
	localparam logic [CODE_W-1:0] KUTEN        = 16'h3002;
	localparam logic [CODE_W-1:0] FULL_COMMA   = 16'hFF0C;
	localparam logic [CODE_W-1:0] FULL_PERIOD  = 16'hFF0E;
	localparam logic [CODE_W-1:0] ASCII_SPACE  = 16'h0020;
	localparam logic [CODE_W-1:0] ASCII_COMMA  = 16'h002C;
	localparam logic [CODE_W-1:0] ASCII_PERIOD = 16'h002E;

	typedef struct packed {
		logic [2:0]        width_select;
		logic [1:0]        punct_style;
		logic              half_symbols;
		logic [DATA_W-1:0] forms_low;
		logic [DATA_W-1:0] forms_second;
		logic [DATA_W-1:0] forms_third;
		logic [DATA_W-1:0] forms_high;
	} cfg_t;

	function automatic logic [CODE_W-1:0] to_width(input logic [CODE_W-1:0] c,
			input logic full);
		logic [CODE_W-1:0] r;
		r = c;
		if (full) begin
			if (c == ASCII_SPACE) begin
				r = IDEO_SPACE;
			end else if (c >= 16'h0021 && c <= 16'h007E) begin
				r = CODE_W'(c + FULL_OFFSET);
			end
		end
		return r;
	endfunction

	function automatic logic [CODE_W-1:0] jp_symbol(input logic [CODE_W-1:0] c,
			input logic half);
		logic [CODE_W-1:0] r;
		r = c;
		if (half) begin
			unique case (c)
				16'h300C: r = 16'hFF62;
				16'h300D: r = 16'hFF63;
				16'h3001: r = 16'hFF64;
				16'h3002: r = 16'hFF61;
				16'h30FB: r = 16'hFF65;
				16'hFF01: r = 16'h0021;
				16'hFF1F: r = 16'h003F;
				default:  r = c;
			endcase
		end
		return r;
	endfunction

	function automatic logic [CODE_W-1:0] jp_mark(input logic [CODE_W-1:0] c);
		logic [CODE_W-1:0] r;
		unique case (c)
			16'h005B: r = 16'h300C;
			16'h005D: r = 16'h300D;
			16'h007B: r = 16'h300E;
			16'h007D: r = 16'h300F;
			16'h002F: r = 16'h30FB;
			16'h002D: r = 16'h30FC;
			16'h007E: r = 16'h301C;
			16'h0021: r = 16'hFF01;
			16'h003F: r = 16'hFF1F;
			default:  r = 16'h0000;
		endcase
		return r;
	endfunction

	function automatic logic is_digit(input logic [CODE_W-1:0] c);
		return c >= 16'h0030 && c <= 16'h0039;
	endfunction

	function automatic logic is_letter(input logic [CODE_W-1:0] c);
		return (c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h0041 && c <= 16'h005A);
	endfunction

endpackage

### rtl/core/ime_character_width_mapper_top.sv
// an accepted input item passes the input register and then the result register before it is valid at the output
// throughput: one item per cycle while the output is not stalled, set by the input and result registers
// each stage holds its item while the stage after it is full and stalled
// reset: arst_n clears both stage valid flags and loads register defaults
// configuration writes are always ready and take effect on the next cycle
`timescale 1ns / 1ps
`include "ime_character_width_mapper_top_macros.svh"
module ime_character_width_mapper_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // char_code
	input  logic [1:0]                     s_tuser,   // kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,   // out_code
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ime_cwm_pkg::IDX_W-1:0]  cfg_index,
	input  logic [ime_cwm_pkg::DATA_W-1:0] cfg_data
);
	import ime_cwm_pkg::*;

	cfg_t              cfg;
	logic              valid_s1;
	kind_t             kind_s1;
	logic [CODE_W-1:0] code_s1;
	logic              valid_s2;
	logic [CODE_W-1:0] code_s2;
	logic [CODE_W-1:0] mapped;
	logic              adv_s2;
	logic              adv_s1;

	assign cfg_ready = 1'b1;

	ime_cwm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			kind_s1 <= kind_t'(s_tuser);
			code_s1 <= s_tdata;
		end
	end

	ime_cwm_map u_map (
		.cfg       (cfg),
		.kind      (kind_s1),
		.char_code (code_s1),
		.out_code  (mapped)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			code_s2 <= mapped;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = code_s2;

	`ASSERT_CLK(a_accept_fills_s1, s_tvalid && s_tready |=> valid_s1)
	`ASSERT_CLK(a_s1_holds_on_stall, valid_s1 && !adv_s2 |=> valid_s1 && $stable(code_s1))
	`ASSERT_NEVER(a_ready_when_out_empty, !valid_s2 && !s_tready)
	`ASSERT_CLK(a_s1_moves_to_s2, valid_s1 && adv_s2 |=> valid_s2)

endmodule

### rtl/core/ime_cwm_cfg.sv
// configuration register bank for the character width mapper
`timescale 1ns / 1ps
module ime_cwm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ime_cwm_pkg::IDX_W-1:0] wr_index,
	input  logic [ime_cwm_pkg::DATA_W-1:0] wr_data,
	output ime_cwm_pkg::cfg_t             cfg
);
	import ime_cwm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_select <= 3'd0;
			cfg_q.punct_style  <= 2'd0;
			cfg_q.half_symbols <= 1'b0;
			cfg_q.forms_low    <= FORMS_LOW_RST;
			cfg_q.forms_second <= FORMS_SECOND_RST;
			cfg_q.forms_third  <= FORMS_THIRD_RST;
			cfg_q.forms_high   <= FORMS_HIGH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH_SELECT: cfg_q.width_select <= wr_data[2:0];
				REG_PUNCT_STYLE:  cfg_q.punct_style  <= wr_data[1:0];
				REG_HALF_SYMBOLS: cfg_q.half_symbols <= wr_data[0];
				REG_FORMS_LOW:    cfg_q.forms_low    <= wr_data;
				REG_FORMS_SECOND: cfg_q.forms_second <= wr_data;
				REG_FORMS_THIRD:  cfg_q.forms_third  <= wr_data;
				REG_FORMS_HIGH:   cfg_q.forms_high   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/ime_cwm_map.sv
// combinational character mapping between the input and result registers
`timescale 1ns / 1ps
module ime_cwm_map (
	input  ime_cwm_pkg::cfg_t              cfg,
	input  ime_cwm_pkg::kind_t             kind,
	input  logic [ime_cwm_pkg::CODE_W-1:0] char_code,
	output logic [ime_cwm_pkg::CODE_W-1:0] out_code
);
	import ime_cwm_pkg::*;

	logic [DATA_W-1:0] forms_word;
	logic [1:0]        form;
	logic [CODE_W-1:0] mark;
	logic [CODE_W-1:0] punct_code;
	logic [CODE_W-1:0] kana_code;
	logic              is_comma;
	logic              alnum_full;

	always_comb begin
		unique case (char_code[6:5])
			2'd0:    forms_word = cfg.forms_low;
			2'd1:    forms_word = cfg.forms_second;
			2'd2:    forms_word = cfg.forms_third;
			default: forms_word = cfg.forms_high;
		endcase
		form = forms_word[{char_code[4:0], 1'b0} +: 2];
		mark = jp_mark(char_code);
	end

	// comma and period styles
	always_comb begin
		is_comma = (char_code == ASCII_COMMA);
		unique case (cfg.punct_style)
			PUNCT_TOUTEN_KUTEN: punct_code = jp_symbol(is_comma ? TOUTEN : KUTEN,
				cfg.half_symbols);
			PUNCT_FULL:         punct_code = is_comma ? FULL_COMMA : FULL_PERIOD;
			PUNCT_HALF:         punct_code = is_comma ? ASCII_COMMA : ASCII_PERIOD;
			PUNCT_TOUTEN_FULL:  punct_code = is_comma ?
				jp_symbol(TOUTEN, cfg.half_symbols) : FULL_PERIOD;
			default:            punct_code = char_code;
		endcase
	end

	always_comb begin
		priority if (is_digit(char_code)) begin
			kana_code = to_width(char_code, cfg.width_select[0]);
		end else if (is_letter(char_code)) begin
			kana_code = to_width(char_code, cfg.width_select[1]);
		end else if (char_code == ASCII_COMMA || char_code == ASCII_PERIOD) begin
			kana_code = punct_code;
		end else if (char_code[15:7] != 9'd0) begin
			kana_code = char_code;
		end else if (form == FORM_FULL) begin
			kana_code = to_width(char_code, 1'b1);
		end else if (form == FORM_JAPANESE) begin
			kana_code = (mark != 16'h0000) ? jp_symbol(mark, cfg.half_symbols)
				: to_width(char_code, 1'b1);
		end else begin
			kana_code = char_code;
		end
	end

	always_comb begin
		alnum_full = is_digit(char_code) ? cfg.width_select[0] : cfg.width_select[1];
		unique case (kind)
			KIND_KANA:  out_code = kana_code;
			KIND_ALNUM: out_code = to_width(char_code, alnum_full);
			KIND_SPACE: out_code = to_width(ASCII_SPACE, cfg.width_select[2]);
			KIND_RAW:   out_code = char_code;
			default:    out_code = char_code;
		endcase
	end

endmodule
